### design/alpe_pkg.sv
// ----------------------------------------------------------------------------
// alpe_pkg
// Shared types and codes for the packed list block: command and response
// beats, action and status codes, sequencer states.
// ----------------------------------------------------------------------------
package alpe_pkg;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_ERASE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  position;
        logic [31:0] value;
    } alpe_cmd_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [8:0]  count;
    } alpe_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SH_READ,
        S_SH_WRITE
    } alpe_state_t;

endpackage

### design/array_list_push_erase.sv
// ----------------------------------------------------------------------------
// array_list_push_erase
// Packed list of data words in a fixed store: push appends, erase removes a
// position and closes the gap, read returns a position.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; its single
// response is shown on rsp for exactly one cycle with done high and must be
// taken then, as the receiver cannot stall it. A push, a rejected command or
// an erase of the last word answers in the cycle after it is taken; a
// read waits in S_READ for the registered read; any other erase moves each
// word behind the position down one place via S_SH_READ and S_SH_WRITE, as
// the entry store has one write and one registered read port and each moved
// word costs one read and one write. busy stays low in the cycle done is
// shown, so the next command may be taken there. The store needs no clearing after reset.
module array_list_push_erase #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  alpe_pkg::alpe_cmd_t cmd,
    output logic                done,
    output alpe_pkg::alpe_rsp_t rsp
);
    import alpe_pkg::*;

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
    localparam int CMP_W  = LEN_W > 8 ? LEN_W : 8;

    alpe_state_t             state_reg, state_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [LEN_W-1:0]        ptr_reg, ptr_next;
    logic                    done_reg, done_next;
    alpe_rsp_t               rsp_reg, rsp_next;

    logic                    we;
    logic [ADDR_W-1:0]       waddr, raddr;
    logic [DATA_WIDTH-1:0]   wdata, rdata;

    logic [LEN_W-1:0]        len_inc, len_dec, ptr_p1;
    logic [LEN_W:0]          ptr_p2;
    logic [CMP_W-1:0]        pos_ext, len_ext;
    logic                    pos_bad, pos_last;

    alpe_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign len_inc  = len_reg + LEN_W'(1);
    assign len_dec  = len_reg - LEN_W'(1);
    assign ptr_p1   = ptr_reg + LEN_W'(1);
    assign ptr_p2   = {1'b0, ptr_reg} + (LEN_W + 1)'(2);
    assign pos_ext  = CMP_W'(cmd.position);
    assign len_ext  = CMP_W'(len_reg);
    assign pos_bad  = pos_ext >= len_ext;
    assign pos_last = (pos_ext + CMP_W'(1)) == len_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        we         = 1'b0;
        waddr      = ptr_reg[ADDR_W-1:0];
        wdata      = rdata;
        raddr      = ptr_p1[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next           = 1'b1;
                    rsp_next.read_value = '0;
                    rsp_next.status     = STAT_OK;
                    rsp_next.count      = 9'(len_reg);
                    unique case (cmd.action)
                        ACT_PUSH:
                        begin
                            if (len_reg >= LEN_W'(CAPACITY))
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                we             = 1'b1;
                                waddr          = len_reg[ADDR_W-1:0];
                                wdata          = DATA_WIDTH'(cmd.value);
                                len_next       = len_inc;
                                rsp_next.count = 9'(len_inc);
                            end
                        end
                        ACT_ERASE:
                        begin
                            if (pos_bad)
                            begin
                                rsp_next.status = STAT_RANGE;
                            end
                            else if (pos_last)
                            begin
                                len_next       = len_dec;
                                rsp_next.count = 9'(len_dec);
                            end
                            else
                            begin
                                // walk the tail down one place, word by word
                                done_next  = 1'b0;
                                ptr_next   = LEN_W'(cmd.position);
                                state_next = S_SH_READ;
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_bad)
                            begin
                                rsp_next.status = STAT_RANGE;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                raddr      = ADDR_W'(cmd.position);
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STAT_RANGE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next           = 1'b1;
                rsp_next.read_value = 32'(rdata);
                rsp_next.status     = STAT_OK;
                rsp_next.count      = 9'(len_reg);
                state_next          = S_IDLE;
            end
            S_SH_READ:
            begin
                state_next = S_SH_WRITE;
            end
            S_SH_WRITE:
            begin
                we = 1'b1;
                if (ptr_p2 < {1'b0, len_reg})
                begin
                    ptr_next   = ptr_p1;
                    state_next = S_SH_READ;
                end
                else
                begin
                    len_next            = len_dec;
                    done_next           = 1'b1;
                    rsp_next.read_value = '0;
                    rsp_next.status     = STAT_OK;
                    rsp_next.count      = 9'(len_dec);
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // the list never outgrows the store
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("list length beyond capacity");

    // a taken command either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("command dropped");

    // the length only moves together with a response beat
    a_len_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != $past(len_reg)) |-> done)
        else $error("length changed without response");

    // shifting only touches words inside the list
    a_shift_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_WRITE) |-> (ptr_p1 < len_reg))
        else $error("shift beyond list end");

    // no response while a command is still in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response while busy");

endmodule

### design/alpe_ram.sv
// ----------------------------------------------------------------------------
// alpe_ram
// Generic single-clock RAM, one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module alpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### tb/sv/tb_array_list_push_erase.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_list_push_erase
// Self-checking bench for the packed list block. A queue of command beats,
// a short directed opening then random traffic with two fill-to-full and
// drain episodes, is fed to the block with random gaps. Every accepted beat
// is run through a local model of the list and the single response that
// comes back is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_array_list_push_erase;

    import alpe_pkg::*;

    localparam int LIST_CAPACITY = 256;
    localparam int SMALL_BAND    = 24;
    localparam int RANDOM_BEATS  = 1950;
    localparam int MAX_GAP       = 15;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 4000000;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    alpe_cmd_t cmd   = '0;
    logic      busy;
    logic      done;
    alpe_rsp_t rsp;

    alpe_cmd_t   pending_cmds[$];
    alpe_rsp_t   expected_rsps[$];
    logic [31:0] list_words[LIST_CAPACITY];
    int          list_len    = 0;
    int          plan_len    = 0;
    int          gap_left    = 0;
    int          calm_left   = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    array_list_push_erase #(
        .CAPACITY   (LIST_CAPACITY),
        .DATA_WIDTH (32)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    // list model: applies one command and returns its response
    function automatic alpe_rsp_t apply_list_cmd(input alpe_cmd_t c);
        alpe_rsp_t r;
        int        k;
        r.read_value = '0;
        r.status     = STAT_OK;
        case (c.action)
            ACT_PUSH:
            begin
                if (list_len >= LIST_CAPACITY)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    list_words[list_len] = c.value;
                    list_len++;
                end
            end
            ACT_ERASE:
            begin
                if (int'(c.position) >= list_len)
                begin
                    r.status = STAT_RANGE;
                end
                else
                begin
                    for (k = int'(c.position); k < list_len - 1; k++)
                        list_words[k] = list_words[k + 1];
                    list_len--;
                end
            end
            ACT_READ:
            begin
                if (int'(c.position) >= list_len)
                    r.status = STAT_RANGE;
                else
                    r.read_value = list_words[c.position];
            end
            default:
            begin
                r.status = STAT_RANGE;
            end
        endcase
        r.count = 9'(list_len);
        return r;
    endfunction

    // idle cycles before the next beat, with runs of back-to-back beats
    function automatic int draw_gap();
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // position inside the planned list with the given odds, else anywhere
    function automatic logic [7:0] pick_position(input int in_range_pct);
        if (plan_len > 0 && $urandom_range(0, 99) < in_range_pct)
            return 8'($urandom_range(0, plan_len - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // plan_len tracks the list length the queued beats will leave behind
    task automatic plan_beat(input logic [1:0] act, input logic [7:0] pos,
                             input logic [31:0] val);
        alpe_cmd_t c;
        c.action   = act;
        c.position = pos;
        c.value    = val;
        pending_cmds.push_back(c);
        if (act == ACT_PUSH && plan_len < LIST_CAPACITY)
            plan_len++;
        else if (act == ACT_ERASE && int'(pos) < plan_len)
            plan_len--;
    endtask

    // short list traffic, cheap erases
    task automatic plan_small_beat();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            plan_beat(ACT_UNUSED, 8'($urandom_range(0, 255)), pick_word());
        else if (r < 40 && plan_len < SMALL_BAND)
            plan_beat(ACT_PUSH, 8'($urandom_range(0, 255)), pick_word());
        else if (r < 70)
            plan_beat(ACT_ERASE, pick_position(75), pick_word());
        else
            plan_beat(ACT_READ, pick_position(75), pick_word());
    endtask

    // grow the list to capacity, poke the full list, then drain it again
    task automatic plan_full_episode();
        int r;
        while (plan_len < LIST_CAPACITY)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                plan_beat(ACT_PUSH, 8'($urandom_range(0, 255)), pick_word());
            else if (r < 96)
                plan_beat(ACT_READ, pick_position(70), pick_word());
            else
                plan_beat(ACT_ERASE, pick_position(100), pick_word());
        end
        repeat (4)
            plan_beat(ACT_PUSH, 8'($urandom_range(0, 255)), pick_word());
        plan_beat(ACT_READ, 8'd255, pick_word());
        plan_beat(ACT_READ, 8'd0, pick_word());
        // longest shift of all
        plan_beat(ACT_ERASE, 8'd0, pick_word());
        plan_beat(ACT_READ, 8'd255, pick_word());
        plan_beat(ACT_PUSH, 8'($urandom_range(0, 255)), pick_word());
        plan_beat(ACT_ERASE, 8'd255, pick_word());
        while (plan_len > 8)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                plan_beat(ACT_ERASE, 8'(plan_len - 1), pick_word());
            else if (r < 75)
                plan_beat(ACT_ERASE, pick_position(100), pick_word());
            else if (r < 95)
                plan_beat(ACT_READ, pick_position(80), pick_word());
            else
                plan_beat(ACT_PUSH, 8'($urandom_range(0, 255)), pick_word());
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        int next_gap;
        if (!rst_n)
        begin
            start    <= 1'b0;
            cmd      <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            expected_rsps.push_back(apply_list_cmd(cmd));
            next_gap = draw_gap();
            if (next_gap == 0 && pending_cmds.size() > 0)
            begin
                cmd <= pending_cmds.pop_front();
            end
            else
            begin
                start    <= 1'b0;
                gap_left <= (next_gap > 0) ? next_gap - 1 : 0;
            end
        end
        else if (!start)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                start <= 1'b1;
                cmd   <= pending_cmds.pop_front();
            end
        end
    end

    always @(posedge clk)
    begin : check_rsps
        alpe_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("response beat with nothing expected: %h", rsp);
                error_count++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value,
                           rsp.read_value);
                    error_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, rsp.count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : run_test
        int directed_beats;
        int episodes;

        // empty list corner cases, then pushes of edge values and reads around the list end
        plan_beat(ACT_READ, 8'd0, pick_word());
        plan_beat(ACT_ERASE, 8'd0, pick_word());
        plan_beat(ACT_ERASE, 8'd255, pick_word());
        plan_beat(ACT_UNUSED, 8'd0, 32'h0000_0000);
        plan_beat(ACT_PUSH, 8'd0, 32'h0000_0000);
        plan_beat(ACT_PUSH, 8'd255, 32'hFFFF_FFFF);
        plan_beat(ACT_PUSH, 8'd170, 32'h5A5A_A5A5);
        plan_beat(ACT_PUSH, 8'd85, 32'hA5A5_5A5A);
        plan_beat(ACT_PUSH, 8'd1, 32'h0000_0001);
        plan_beat(ACT_READ, 8'd0, 32'hFFFF_FFFF);
        plan_beat(ACT_READ, 8'd4, 32'h0000_0000);
        plan_beat(ACT_READ, 8'd5, pick_word());
        plan_beat(ACT_READ, 8'd255, pick_word());
        // erase in the middle closes the gap
        plan_beat(ACT_ERASE, 8'd1, pick_word());
        plan_beat(ACT_READ, 8'd1, pick_word());
        // erase of the last word only shortens
        plan_beat(ACT_ERASE, 8'd3, pick_word());
        plan_beat(ACT_ERASE, 8'd3, pick_word());
        plan_beat(ACT_READ, 8'd2, pick_word());
        plan_beat(ACT_ERASE, 8'd0, pick_word());
        plan_beat(ACT_ERASE, 8'd0, pick_word());
        plan_beat(ACT_ERASE, 8'd0, pick_word());
        plan_beat(ACT_READ, 8'd0, pick_word());
        plan_beat(ACT_UNUSED, 8'd255, 32'hFFFF_FFFF);
        directed_beats = pending_cmds.size();

        episodes = 0;
        while (pending_cmds.size() < directed_beats + RANDOM_BEATS)
        begin
            if ((episodes == 0 && pending_cmds.size() >= directed_beats + 300) ||
                (episodes == 1 && pending_cmds.size() >= directed_beats + 1100))
            begin
                plan_full_episode();
                episodes++;
            end
            else
            begin
                plan_small_beat();
            end
        end

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || start)
            @(posedge clk);
        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_rsps.size() > 0)
        begin
            $error("%0d responses never arrived", expected_rsps.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
